// ===== rtl/bfi_pkg.sv =====
// ----------------------------------------------------------------------------
// Beam gap-fill interpolator package
// Shared sizes, register indexes, sequencer states and the request structs
// that pass between the controller, the beam memory and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package bfi_pkg;

    localparam int MAX_GATES = 1024;
    localparam int ADDR_W    = $clog2(MAX_GATES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int VAL_W     = 16;
    // Interpolation numerator: a 16-bit value times a gate distance, plus a step.
    localparam int NUM_W     = VAL_W + ADDR_W + 1;
    // Quotient magnitude never exceeds 2^15, so 16 quotient bits suffice.
    localparam int QUOT_W    = VAL_W;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

    localparam logic REG_VALID_MIN = 1'b0;
    localparam logic REG_VALID_MAX = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN_RD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FILL,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [ADDR_W-1:0]       den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== rtl/bfi_ram.sv =====
// ----------------------------------------------------------------------------
// Beam store
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module bfi_ram
    import bfi_pkg::*;
(
    input  logic             i_clk,
    input  t_ram_req         i_req,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [MAX_GATES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bfi_div.sv =====
// ----------------------------------------------------------------------------
// Interpolation divider
// Signed numerator over an unsigned gate distance, truncated toward zero.
// Restoring division on the magnitude, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfi_div
    import bfi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_rem;
    logic [QUOT_W-1:0]    r_quo;
    logic [ADDR_W-1:0]    r_den;
    logic                 r_neg;

    logic [NUM_W-1:0]  w_abs;
    logic [ADDR_W:0]   w_trial;
    logic [ADDR_W-1:0] w_rem;
    logic [QUOT_W-1:0] w_quo;
    logic [QUOT_W-1:0] w_neg_quo;

    assign w_abs = i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);

    // The quotient fits in QUOT_W bits, so the bits above it start out as a
    // partial remainder already below the divisor.
    always_comb begin
        w_rem   = r_rem;
        w_quo   = r_quo;
        w_trial = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            w_trial = {w_rem, w_quo[QUOT_W-1]};
            w_quo   = {w_quo[QUOT_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_rem    = ADDR_W'(w_trial - {1'b0, r_den});
                w_quo[0] = 1'b1;
            end else begin
                w_rem = w_trial[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= w_abs[QUOT_W+ADDR_W-1:QUOT_W];
            r_quo <= w_abs[QUOT_W-1:0];
            r_den <= i_req.den;
            r_neg <= i_req.num[NUM_W-1];
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= w_quo;
        end
    end

    assign w_neg_quo = QUOT_W'(0) - r_quo;
    assign o_done    = r_done;
    assign o_quot    = $signed(r_neg ? w_neg_quo : r_quo);

endmodule

`default_nettype wire

// ===== rtl/beam_gap_fill_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Beam gap-fill interpolator
// Loads a beam of signed Q8.8 gates, fills out-of-window gates in place by
// edge hold and linear interpolation, then returns the filled gates in order.
// ----------------------------------------------------------------------------
// Usage.
// Items enter on the command channel: a word is taken at a clock edge where
// start is high and busy is low. A load word (mode 0) writes one gate and
// produces no result. A load word marked end_of_beam, or the one that lands
// on the last gate slot, starts the fill pass and raises busy. The fill pass
// scans the stored beam once, reading and then checking each gate. Leading,
// trailing and all-missing gates are written directly; every gate in an
// interior gap goes through the divider that forms its interpolated value,
// and each gap first forms its numerator in a multiply state. A drain word
// (mode 1) reads the next filled gate: busy is high for one cycle, the
// read gate is registered onto the result ports and marked by o_res_strobe
// for exactly one cycle, and busy holds off the next word until the read
// is done. The receiver cannot stall. A drain with no filled beam gives
// no result. The configuration channel writes valid_min and valid_max
// while busy is low. Reset is synchronous; it empties the beam, clears the
// load, read and scan pointers and restores the full window. The beam store
// holds no reset value and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module beam_gap_fill_interpolator_top
    import bfi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command channel
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_mode,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic                    i_end_of_beam,
    // Configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [VAL_W-1:0]        i_cfg_data,
    // Result channel
    output logic                    o_res_strobe,
    output logic signed [VAL_W-1:0] o_filled_value,
    output logic [ADDR_W-1:0]       o_gate_index,
    output logic                    o_last_gate
);

    t_state r_state, n_state;

    // Control state
    logic [ADDR_W-1:0]       r_load_ptr, n_load_ptr;
    logic [CNT_W-1:0]        r_gate_count, n_gate_count;
    logic [ADDR_W-1:0]       r_read_ptr, n_read_ptr;
    logic                    r_beam_ready, n_beam_ready;
    logic signed [VAL_W-1:0] r_valid_min, n_valid_min;
    logic signed [VAL_W-1:0] r_valid_max, n_valid_max;
    logic                    r_strobe, n_strobe;

    // Fill pass working registers
    logic [CNT_W-1:0]        r_scan, n_scan;
    logic                    r_have, n_have;
    logic [ADDR_W-1:0]       r_a, n_a;
    logic signed [VAL_W-1:0] r_va, n_va;
    logic [ADDR_W-1:0]       r_b, n_b;
    logic signed [VAL_W-1:0] r_vb, n_vb;
    logic [ADDR_W-1:0]       r_k, n_k;
    logic [ADDR_W-1:0]       r_d, n_d;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic signed [VAL_W:0]   r_delta, n_delta;
    logic [ADDR_W-1:0]       r_fill_ptr, n_fill_ptr;
    logic [CNT_W-1:0]        r_fill_end, n_fill_end;
    logic signed [VAL_W-1:0] r_fill_val, n_fill_val;
    logic                    r_fill_tail, n_fill_tail;

    // Result word
    logic signed [VAL_W-1:0] r_out_value, n_out_value;
    logic [ADDR_W-1:0]       r_out_index, n_out_index;
    logic                    r_out_last, n_out_last;

    t_ram_req                ram_req;
    logic [VAL_W-1:0]        ram_rdata;
    t_div_req                div_req;
    logic                    div_done;
    logic signed [VAL_W-1:0] div_quot;

    logic                    w_accept;
    logic                    w_load;
    logic                    w_load_end;
    logic                    w_drain;
    logic signed [VAL_W-1:0] w_gate;
    logic                    w_gate_ok;
    logic                    w_scan_end;
    logic                    w_need_tail;
    logic                    w_gap;
    logic                    w_lead;
    logic                    w_fill_done;
    logic                    w_gap_done;
    logic signed [NUM_W-1:0] w_prod;
    logic signed [VAL_W:0]   w_delta;

    bfi_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    bfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Handshake decode. A drain is only taken as work when a filled beam waits.
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = ~busy;
    assign w_accept    = start & ~busy;
    assign w_load      = w_accept & (i_mode == MODE_LOAD);
    assign w_load_end  = w_load & (i_end_of_beam | (r_load_ptr == ADDR_W'(MAX_GATES - 1)));
    assign w_drain     = w_accept & (i_mode == MODE_DRAIN) & r_beam_ready;

    // Scan decode. The gate under test is the one addressed in the previous
    // cycle; only gates behind the scan pointer are ever rewritten, so the
    // scan always sees loaded values.
    assign w_gate      = $signed(ram_rdata);
    assign w_gate_ok   = (w_gate >= r_valid_min) && (w_gate <= r_valid_max);
    assign w_scan_end  = (r_scan == r_gate_count);
    assign w_need_tail = !r_have || (({1'b0, r_a} + 1'b1) != r_gate_count);
    assign w_gap       = w_gate_ok && r_have && (r_scan != ({1'b0, r_a} + 1'b1));
    assign w_lead      = w_gate_ok && !r_have && (r_scan != '0);
    assign w_fill_done = (({1'b0, r_fill_ptr} + 1'b1) == r_fill_end);
    assign w_gap_done  = ((r_k + 1'b1) == r_b);

    // The first interpolated numerator is va*d + (vb - va); later gates of the
    // same gap add (vb - va) once more each.
    assign w_delta = (VAL_W + 1)'(r_vb) - (VAL_W + 1)'(r_va);
    assign w_prod  = NUM_W'(r_va) * NUM_W'($signed({1'b0, r_d}));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load_end) begin
                    n_state = ST_SCAN_RD;
                end else if (w_drain) begin
                    n_state = ST_DRAIN_RD;
                end
            end
            ST_DRAIN_RD: begin
                n_state = ST_IDLE;
            end
            ST_SCAN_RD: begin
                if (w_scan_end) begin
                    n_state = w_need_tail ? ST_FILL : ST_IDLE;
                end else begin
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (w_gap) begin
                    n_state = ST_MUL;
                end else if (w_lead) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_FILL: begin
                if (w_fill_done) begin
                    n_state = r_fill_tail ? ST_IDLE : ST_SCAN_RD;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = w_gap_done ? ST_SCAN_RD : ST_DIV_GO;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory and divider requests
    always_comb begin
        ram_req       = '0;
        ram_req.raddr = (r_state == ST_IDLE) ? r_read_ptr : r_scan[ADDR_W-1:0];
        div_req       = '0;
        div_req.num   = r_num;
        div_req.den   = r_d;
        case (r_state)
            ST_IDLE: begin
                ram_req.we    = w_load;
                ram_req.waddr = r_load_ptr;
                ram_req.wdata = i_sample_value;
            end
            ST_FILL: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_fill_ptr;
                ram_req.wdata = r_fill_val;
            end
            ST_DIV_GO: begin
                div_req.start = 1'b1;
            end
            ST_DIV_WAIT: begin
                ram_req.we    = div_done;
                ram_req.waddr = r_k;
                ram_req.wdata = div_quot;
            end
            default: begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    // Next values of the working registers
    always_comb begin
        n_load_ptr   = r_load_ptr;
        n_gate_count = r_gate_count;
        n_read_ptr   = r_read_ptr;
        n_beam_ready = r_beam_ready;
        n_valid_min  = r_valid_min;
        n_valid_max  = r_valid_max;
        n_strobe     = 1'b0;
        n_scan       = r_scan;
        n_have       = r_have;
        n_a          = r_a;
        n_va         = r_va;
        n_b          = r_b;
        n_vb         = r_vb;
        n_k          = r_k;
        n_d          = r_d;
        n_num        = r_num;
        n_delta      = r_delta;
        n_fill_ptr   = r_fill_ptr;
        n_fill_end   = r_fill_end;
        n_fill_val   = r_fill_val;
        n_fill_tail  = r_fill_tail;
        n_out_value  = r_out_value;
        n_out_index  = r_out_index;
        n_out_last   = r_out_last;

        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_VALID_MIN) begin
                n_valid_min = $signed(i_cfg_data);
            end else begin
                n_valid_max = $signed(i_cfg_data);
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    // A new load abandons any beam still being drained.
                    n_beam_ready = 1'b0;
                    if (w_load_end) begin
                        n_gate_count = {1'b0, r_load_ptr} + 1'b1;
                        n_load_ptr   = '0;
                        n_read_ptr   = '0;
                        n_scan       = '0;
                        n_have       = 1'b0;
                    end else begin
                        n_load_ptr = r_load_ptr + 1'b1;
                    end
                end
                if (w_drain) begin
                    n_out_index = r_read_ptr;
                    n_out_last  = (({1'b0, r_read_ptr} + 1'b1) == r_gate_count);
                    if (({1'b0, r_read_ptr} + 1'b1) == r_gate_count) begin
                        n_beam_ready = 1'b0;
                        n_read_ptr   = '0;
                    end else begin
                        n_read_ptr = r_read_ptr + 1'b1;
                    end
                end
            end
            ST_DRAIN_RD: begin
                n_out_value = w_gate;
                n_strobe    = 1'b1;
            end
            ST_SCAN_RD: begin
                if (w_scan_end) begin
                    n_fill_end  = r_gate_count;
                    n_fill_tail = 1'b1;
                    if (!r_have) begin
                        // No gate in the window: the whole beam takes valid_min.
                        n_fill_ptr = '0;
                        n_fill_val = r_valid_min;
                    end else if (w_need_tail) begin
                        n_fill_ptr = r_a + 1'b1;
                        n_fill_val = r_va;
                    end else begin
                        n_beam_ready = 1'b1;
                    end
                end
            end
            ST_SCAN_CHK: begin
                if (w_gap) begin
                    n_b = r_scan[ADDR_W-1:0];
                    n_vb = w_gate;
                    n_k = r_a + 1'b1;
                    n_d = ADDR_W'(r_scan - {1'b0, r_a});
                end else begin
                    n_scan = r_scan + 1'b1;
                    if (w_gate_ok) begin
                        n_have = 1'b1;
                        n_a    = r_scan[ADDR_W-1:0];
                        n_va   = w_gate;
                    end
                    if (w_lead) begin
                        // Gates ahead of the first valid one copy its value.
                        n_fill_ptr  = '0;
                        n_fill_end  = r_scan;
                        n_fill_val  = w_gate;
                        n_fill_tail = 1'b0;
                    end
                end
            end
            ST_FILL: begin
                n_fill_ptr = r_fill_ptr + 1'b1;
                if (w_fill_done && r_fill_tail) begin
                    n_beam_ready = 1'b1;
                end
            end
            ST_MUL: begin
                n_num   = w_prod + NUM_W'(w_delta);
                n_delta = w_delta;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_num = r_num + NUM_W'(r_delta);
                    if (w_gap_done) begin
                        n_a    = r_b;
                        n_va   = r_vb;
                        n_scan = r_scan + 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_load_ptr   <= '0;
            r_gate_count <= '0;
            r_read_ptr   <= '0;
            r_beam_ready <= 1'b0;
            r_valid_min  <= VAL_W'(16'sh8000);
            r_valid_max  <= VAL_W'(16'sh7FFF);
            r_strobe     <= 1'b0;
            r_scan       <= '0;
            r_have       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_ptr   <= n_load_ptr;
            r_gate_count <= n_gate_count;
            r_read_ptr   <= n_read_ptr;
            r_beam_ready <= n_beam_ready;
            r_valid_min  <= n_valid_min;
            r_valid_max  <= n_valid_max;
            r_strobe     <= n_strobe;
            r_scan       <= n_scan;
            r_have       <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_va        <= n_va;
        r_b         <= n_b;
        r_vb        <= n_vb;
        r_k         <= n_k;
        r_d         <= n_d;
        r_num       <= n_num;
        r_delta     <= n_delta;
        r_fill_ptr  <= n_fill_ptr;
        r_fill_end  <= n_fill_end;
        r_fill_val  <= n_fill_val;
        r_fill_tail <= n_fill_tail;
        r_out_value <= n_out_value;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    assign o_res_strobe   = r_strobe;
    assign o_filled_value = r_out_value;
    assign o_gate_index   = r_out_index;
    assign o_last_gate    = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/bfi_chk.sv =====
// ----------------------------------------------------------------------------
// Beam gap-fill interpolator port checker
// Timing relations between command words, busy and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module bfi_chk
    import bfi_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_mode,
    input logic              i_end_of_beam,
    input logic              o_res_strobe,
    input logic [ADDR_W-1:0] o_gate_index,
    input logic              o_last_gate
);

    // Every result word answers a drain word taken earlier.
    a_res_follows_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(start && !busy && (i_mode == MODE_DRAIN), 2))
        else $error("result word without a drain word two cycles earlier");

    // Drains are spaced by the memory read, so result words never touch.
    a_res_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result words in two adjacent cycles");

    // A load word that closes a beam always starts the fill pass.
    a_fill_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_mode == MODE_LOAD) && i_end_of_beam |=> busy)
        else $error("end of beam did not start the fill pass");

    // Reset leaves the block idle with no result word pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_res_strobe))
        else $error("block not idle after reset");

    // A result word from the top gate slot always carries the last-gate flag.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_last_gate |-> (o_gate_index != ADDR_W'(MAX_GATES - 1)))
        else $error("top gate slot returned without the last-gate flag");

endmodule

bind beam_gap_fill_interpolator_top bfi_chk u_bfi_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Beam gap-fill interpolator testbench
// Drives load and drain words into the interpolator, predicts every filled
// gate with a behavioral copy of the fill rules and checks each result word.
// The run covers edge hold, interior interpolation, all-missing beams, empty
// windows, abandoned beams and a long beam, under several windows.
// ----------------------------------------------------------------------------

module tb_top;

    import bfi_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------------
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 22;
    // Words presented in this range skip the random idling; each still waits for its handshake.
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 420;
    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 32;
    localparam int LONG_BEAM     = 120;
    localparam int END_WAIT      = 20000;
    localparam int TAIL_CYCLES   = 16;
    localparam int RUN_LIMIT     = 3_200_000;

    // A queued word is either a command for the block, a register write, or
    // a marker that makes the sender wait until every result has arrived.
    typedef enum logic [1:0] {
        WORD_CMD,
        WORD_CFG,
        WORD_SYNC
    } t_word_kind;

    typedef struct packed {
        t_word_kind              kind;
        logic                    mode;
        logic signed [VAL_W-1:0] sample;
        logic                    eob;
        logic                    cfg_index;
        logic [VAL_W-1:0]        cfg_data;
    } t_bus_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] filled;
        logic [ADDR_W-1:0]       gate;
        logic                    is_last;
    } t_gate_result;

    // ------------------------------------------------------------------------
    // Block signals; every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    start          = 1'b0;
    logic                    busy;
    logic                    i_mode         = 1'b0;
    logic signed [VAL_W-1:0] i_sample_value = '0;
    logic                    i_end_of_beam  = 1'b0;
    logic                    i_cfg_valid    = 1'b0;
    logic                    o_cfg_ready;
    logic                    i_cfg_index    = 1'b0;
    logic [VAL_W-1:0]        i_cfg_data     = '0;
    logic                    o_res_strobe;
    logic signed [VAL_W-1:0] o_filled_value;
    logic [ADDR_W-1:0]       o_gate_index;
    logic                    o_last_gate;

    beam_gap_fill_interpolator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_sample_value (i_sample_value),
        .i_end_of_beam  (i_end_of_beam),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_res_strobe   (o_res_strobe),
        .o_filled_value (o_filled_value),
        .o_gate_index   (o_gate_index),
        .o_last_gate    (o_last_gate)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------------
    t_bus_word    pending_words[$];
    t_gate_result expected_gates[$];

    // Handshakes seen at the last rising edge, read by the driver.
    logic cmd_fire_q = 1'b0;
    logic cfg_fire_q = 1'b0;
    logic busy_q     = 1'b0;

    bit holding     = 1'b0;
    int settle_left = 0;
    int words_sent  = 0;

    int mismatches    = 0;
    int gates_checked = 0;
    int loads_taken   = 0;
    int drains_taken  = 0;
    int beams_filled  = 0;
    int cfg_writes    = 0;

    // Generator's view of the window, used to aim samples in or out of it.
    int gen_lo = -32768;
    int gen_hi = 32767;

    // ------------------------------------------------------------------------
    // Behavioral copy of the interpolator
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] beam_model [MAX_GATES];
    int                      model_gate_count = 0;
    int                      model_load_ptr   = 0;
    int                      model_read_ptr   = 0;
    bit                      model_beam_ready = 1'b0;
    logic signed [VAL_W-1:0] win_min = -16'sd32768;
    logic signed [VAL_W-1:0] win_max = 16'sd32767;

    function automatic bit in_window(logic signed [VAL_W-1:0] v);
        return (v >= win_min) && (v <= win_max);
    endfunction

    // Fills the first n gates in place: leading gates copy the first valid
    // gate, interior gaps are interpolated between their neighbors and
    // truncated toward zero, trailing gates hold the last valid gate.
    function automatic void fill_gaps(int n);
        int     first;
        int     i;
        int     a;
        int     b;
        int     k;
        longint va;
        longint vb;
        longint num;
        first = 0;
        while (first < n && !in_window(beam_model[first]))
            first++;
        if (first >= n) begin
            // Nothing in the window: the whole beam takes valid_min.
            for (i = 0; i < n; i++)
                beam_model[i] = win_min;
            return;
        end
        for (i = 0; i < first; i++)
            beam_model[i] = beam_model[first];
        i = first + 1;
        while (i < n) begin
            if (in_window(beam_model[i])) begin
                i++;
            end else begin
                a = i - 1;
                b = i + 1;
                while (b < n && !in_window(beam_model[b]))
                    b++;
                if (b >= n) begin
                    for (k = i; k < n; k++)
                        beam_model[k] = beam_model[a];
                    return;
                end
                va = beam_model[a];
                vb = beam_model[b];
                for (k = i; k < b; k++) begin
                    num = va * (b - k) + vb * (k - a);
                    beam_model[k] = VAL_W'(num / (b - a));
                end
                i = b + 1;
            end
        end
    endfunction

    // Advances the copy by one accepted command word and queues the result
    // that a drain is due to return.
    function automatic void apply_command(logic mode, logic signed [VAL_W-1:0] sample,
                                          logic eob);
        int           p;
        t_gate_result r;
        if (mode == MODE_LOAD) begin
            loads_taken++;
            p = model_load_ptr;
            if (p >= MAX_GATES)
                p = MAX_GATES - 1;
            // Any beam still being drained is dropped by a new load.
            model_beam_ready = 1'b0;
            beam_model[p] = sample;
            // The last slot closes the beam even without end_of_beam.
            if (eob || p == MAX_GATES - 1) begin
                model_gate_count = p + 1;
                fill_gaps(model_gate_count);
                model_beam_ready = 1'b1;
                model_read_ptr   = 0;
                model_load_ptr   = 0;
                beams_filled++;
            end else begin
                model_load_ptr = p + 1;
            end
        end else begin
            drains_taken++;
            if (model_beam_ready && model_read_ptr < model_gate_count) begin
                r.filled  = beam_model[model_read_ptr];
                r.gate    = ADDR_W'(model_read_ptr);
                r.is_last = (model_read_ptr + 1 == model_gate_count);
                expected_gates = {expected_gates, r};
                if (r.is_last) begin
                    model_beam_ready = 1'b0;
                    model_read_ptr   = 0;
                end else begin
                    model_read_ptr++;
                end
            end
        end
    endfunction

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents one queued word at a time, changing inputs on the
    // falling edge. A word stays on the bus until its handshake is seen; the
    // next word may then go out at the same falling edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : driver_proc
        logic      next_start;
        logic      next_cfg_valid;
        t_bus_word w;
        next_start     = start;
        next_cfg_valid = i_cfg_valid;
        if (start && cmd_fire_q)
            next_start = 1'b0;
        if (i_cfg_valid && cfg_fire_q)
            next_cfg_valid = 1'b0;
        if (i_rst_n && !next_start && !next_cfg_valid) begin
            if (holding) begin
                // Wait for every result, then for the settle count to run down and the block to go idle.
                if (expected_gates.size() != 0)
                    settle_left = SETTLE_CYCLES;
                else if (settle_left != 0)
                    settle_left--;
                else if (!busy_q)
                    holding = 1'b0;
            end else if (pending_words.size() != 0 &&
                         ((words_sent >= QUIET_FIRST && words_sent < QUIET_LAST) ||
                          $urandom_range(0, 99) >= IDLE_PCT)) begin
                w = pending_words.pop_front();
                words_sent++;
                case (w.kind)
                    WORD_SYNC: begin
                        holding     = 1'b1;
                        settle_left = SETTLE_CYCLES;
                    end
                    WORD_CFG: begin
                        next_cfg_valid = 1'b1;
                        i_cfg_index   <= w.cfg_index;
                        i_cfg_data    <= w.cfg_data;
                    end
                    default: begin
                        next_start      = 1'b1;
                        i_mode         <= w.mode;
                        i_sample_value <= w.sample;
                        i_end_of_beam  <= w.eob;
                    end
                endcase
            end
        end
        start       <= next_start;
        i_cfg_valid <= next_cfg_valid;
    end

    // ------------------------------------------------------------------------
    // Monitor: samples at the rising edge, checks result words against the
    // oldest expectation and feeds accepted words to the copy.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_proc
        t_gate_result want;
        if (!i_rst_n) begin
            cmd_fire_q <= 1'b0;
            cfg_fire_q <= 1'b0;
            busy_q     <= 1'b0;
        end else begin
            cmd_fire_q <= start && !busy;
            cfg_fire_q <= i_cfg_valid && o_cfg_ready;
            busy_q     <= busy;
            if (o_res_strobe) begin
                if (expected_gates.size() == 0) begin
                    mismatches++;
                    $display("%0t: stray result, expected none, actual %0d/%0d/%0b",
                             $time, o_filled_value, o_gate_index, o_last_gate);
                end else begin
                    want = expected_gates.pop_front();
                    gates_checked++;
                    check_field("filled_value", want.filled, o_filled_value);
                    check_field("gate_index", want.gate, o_gate_index);
                    check_field("last_gate", want.is_last, o_last_gate);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index == REG_VALID_MIN)
                    win_min = i_cfg_data;
                else
                    win_max = i_cfg_data;
            end
            if (start && !busy)
                apply_command(i_mode, i_sample_value, i_end_of_beam);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_load(logic signed [VAL_W-1:0] sample, logic eob);
        t_bus_word w;
        w           = '0;
        w.kind      = WORD_CMD;
        w.mode      = MODE_LOAD;
        w.sample    = sample;
        w.eob       = eob;
        w.cfg_index = 1'($urandom);
        w.cfg_data  = VAL_W'($urandom);
        pending_words = {pending_words, w};
    endtask

    // The sample and end-of-beam bits ride along at random; a drain ignores them.
    task automatic queue_drain();
        t_bus_word w;
        w        = '0;
        w.kind   = WORD_CMD;
        w.mode   = MODE_DRAIN;
        w.sample = VAL_W'($urandom);
        w.eob    = 1'($urandom);
        pending_words = {pending_words, w};
    endtask

    task automatic queue_sync();
        t_bus_word w;
        w      = '0;
        w.kind = WORD_SYNC;
        pending_words = {pending_words, w};
    endtask

    // Waits for the block to go idle, then writes both window registers in
    // a random order.
    task automatic queue_window(int lo, int hi);
        t_bus_word w_min;
        t_bus_word w_max;
        queue_sync();
        w_min           = '0;
        w_min.kind      = WORD_CFG;
        w_min.cfg_index = REG_VALID_MIN;
        w_min.cfg_data  = VAL_W'(lo);
        w_max           = w_min;
        w_max.cfg_index = REG_VALID_MAX;
        w_max.cfg_data  = VAL_W'(hi);
        if ($urandom_range(0, 1) == 0)
            pending_words = {pending_words, w_min, w_max};
        else
            pending_words = {pending_words, w_max, w_min};
        gen_lo = lo;
        gen_hi = hi;
    endtask

    // Picks a sample inside or outside [lo, hi], with the edges of the window
    // turning up often and, now and then, any Q8.8 value.
    function automatic logic signed [VAL_W-1:0] pick_value(int lo, int hi, bit want_valid);
        int v;
        if ($urandom_range(0, 9) == 0 || lo > hi) begin
            v = $urandom;
        end else if (want_valid) begin
            case ($urandom_range(0, 7))
                0:       v = lo;
                1:       v = hi;
                default: v = lo + int'($urandom_range(0, hi - lo));
            endcase
        end else if (lo > -32768 && (hi == 32767 || $urandom_range(0, 1) == 1)) begin
            v = ($urandom_range(0, 3) == 0) ? lo - 1
                                            : -32768 + int'($urandom_range(0, lo + 32767));
        end else if (hi < 32767) begin
            v = ($urandom_range(0, 3) == 0) ? hi + 1
                                            : hi + 1 + int'($urandom_range(0, 32766 - hi));
        end else begin
            v = $urandom;
        end
        return VAL_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus_proc
        int win_lo_tbl [7];
        int win_hi_tbl [7];
        int g;
        int len;
        int pct;
        int n;
        int ph;
        int lo;
        int hi;
        int phase_items;
        int wait_cycles;

        win_lo_tbl = '{-32768, -32768, 32767, -2000, 100, -32768, 0};
        win_hi_tbl = '{ 32767, -32768, 32767,  3000, -100,     0, 32767};

        // Directed part. A drain before any beam exists gives nothing.
        queue_drain();
        // Leading gap, an interior gap and a trailing gap, with the extreme
        // samples on the missing gates; the extra drain finds no beam.
        queue_window(-256, 256);
        queue_load(-16'sd32768, 1'b0);
        queue_load(16'sd100, 1'b0);
        queue_load(16'sd32767, 1'b0);
        queue_load(-16'sd200, 1'b0);
        queue_load(16'sd32767, 1'b1);
        repeat (6) queue_drain();
        // A beam half drained and then abandoned by a new one-gate beam.
        queue_load(-16'sd256, 1'b0);
        queue_load(16'sd256, 1'b1);
        queue_drain();
        queue_load(16'sd0, 1'b1);
        repeat (2) queue_drain();
        // Empty window: every gate takes valid_min.
        queue_window(1, 0);
        queue_load(16'sd7, 1'b0);
        queue_load(-16'sd7, 1'b1);
        repeat (2) queue_drain();

        // A long beam with random gaps, drained in full plus one extra drain.
        queue_window(-16384, 16383);
        for (g = 0; g < LONG_BEAM; g++)
            queue_load(pick_value(gen_lo, gen_hi, $urandom_range(0, 99) < 70),
                       g == LONG_BEAM - 1);
        repeat (LONG_BEAM + 1) queue_drain();

        // Random part: several windows, mostly well-formed beams with random
        // content, plus stray drains, partial drains and abandoned beams.
        for (ph = 0; ph < 9; ph++) begin
            if (ph < 7) begin
                lo = win_lo_tbl[ph];
                hi = win_hi_tbl[ph];
            end else begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = int'($urandom_range(0, 65535)) - 32768;
                if (ph == 7 && lo > hi) begin
                    n  = lo;
                    lo = hi;
                    hi = n;
                end
            end
            queue_window(lo, hi);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(49, 120);
                    1, 2, 3: len = $urandom_range(13, 48);
                    default: len = $urandom_range(1, 12);
                endcase
                case ($urandom_range(0, 4))
                    0:       pct = 0;
                    1:       pct = 15;
                    2:       pct = 50;
                    3:       pct = 85;
                    default: pct = 100;
                endcase
                if ($urandom_range(0, 19) == 0)
                    queue_drain();
                for (g = 0; g < len; g++) begin
                    // A drain among the loads finds no filled beam unless it comes before the first one.
                    if ($urandom_range(0, 29) == 0)
                        queue_drain();
                    queue_load(pick_value(gen_lo, gen_hi, $urandom_range(0, 99) < pct),
                               g == len - 1);
                end
                if ($urandom_range(0, 9) < 7)
                    n = len + (($urandom_range(0, 2) == 0) ? 1 : 0);
                else
                    n = $urandom_range(0, len - 1);
                repeat (n) queue_drain();
                phase_items += len + ((n < len) ? n : len);
                if ($urandom_range(0, 9) == 0)
                    queue_sync();
            end
        end

        // Reset for the stated number of cycles, released on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || start || i_cfg_valid || holding)
            @(posedge i_clk);
        wait_cycles = 0;
        while (expected_gates.size() != 0 && wait_cycles < END_WAIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_gates.size() != 0) begin
            mismatches++;
            $display("%0t: result words missing, expected %0d more, actual 0",
                     $time, expected_gates.size());
        end

        $display("Covered %0d loads and %0d drains, %0d filled beams, %0d register writes.",
                 loads_taken, drains_taken, beams_filled, cfg_writes);
        $display("Checked %0d returned gates; %0d field errors seen.",
                 gates_checked, mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Hard stop in case the block hangs or stops answering.
    initial begin
        #(RUN_LIMIT);
        $display("tb_top failed");
        $finish;
    end

endmodule
